// ===== rtl/qxmm_pkg.sv =====
// ----------------------------------------------------------------------------
// qxmm_pkg
// shared widths, types and register indexes of the quad-x motor mixer
// ----------------------------------------------------------------------------
package qxmm_pkg;

  localparam int FRAC_BITS = 14;
  localparam int CMD_W     = 16;
  localparam int LANES     = 4;
  localparam int PWM_W     = 12;
  localparam int PWM_SPAN  = 1000;

  // sum of four Q2.14 terms with throttle clamped to 0..1.0
  localparam int MIX_W     = CMD_W + 2;
  // divider remainder holds twice the divisor
  localparam int DIV_W     = MIX_W;
  // quotient reaches 1.0 exactly when a mix equals the divisor
  localparam int Q_W       = FRAC_BITS + 1;
  localparam int DIV_STEPS = FRAC_BITS + 1;
  localparam int DIV_STAGES = 5;
  localparam int STEPS_PER_STAGE = (DIV_STEPS + DIV_STAGES - 1) / DIV_STAGES;
  localparam int SPAN_W    = 10;
  localparam int PROD_W    = Q_W + SPAN_W;

  localparam logic [DIV_W-1:0]        ONE   = DIV_W'(1) << FRAC_BITS;
  localparam logic signed [MIX_W-1:0] ONE_S = $signed(ONE);

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_PWM_FLOOR   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PWM_CEILING = 1'd1;

  localparam logic [PWM_W-1:0] PWM_FLOOR_RST   = 12'd1000;
  localparam logic [PWM_W-1:0] PWM_CEILING_RST = 12'd2000;

  typedef logic [LANES-1:0][MIX_W-1:0] mix_vec_t;
  typedef logic [LANES-1:0][PWM_W-1:0] pwm_vec_t;
  typedef logic [LANES-1:0][Q_W-1:0]   quot_vec_t;

  typedef struct packed {
    logic [DIV_W-1:0]              divisor;
    logic [LANES-1:0][DIV_W-1:0]   num;
  } div_in_t;

  typedef struct packed {
    logic [DIV_W-1:0]              divisor;
    logic [LANES-1:0][DIV_W-1:0]   rem;
    logic [LANES-1:0][Q_W-1:0]     quot;
  } div_stage_t;

  function automatic logic signed [MIX_W-1:0] sx(input logic [CMD_W-1:0] v);
    sx = $signed({{(MIX_W-CMD_W){v[CMD_W-1]}}, v});
  endfunction

  function automatic logic signed [MIX_W-1:0] smax(input logic signed [MIX_W-1:0] a,
                                                   input logic signed [MIX_W-1:0] b);
    smax = (b > a) ? b : a;
  endfunction

endpackage

// ===== rtl/qxmm_mix.sv =====
// ----------------------------------------------------------------------------
// qxmm_mix
// throttle clamp, four quad-x mixes, then largest mix and divider operands
// ----------------------------------------------------------------------------
module qxmm_mix (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [qxmm_pkg::CMD_W-1:0]    throttle_cmd,
  input  logic [qxmm_pkg::CMD_W-1:0]    roll_cmd,
  input  logic [qxmm_pkg::CMD_W-1:0]    pitch_cmd,
  input  logic [qxmm_pkg::CMD_W-1:0]    yaw_cmd,
  output logic                          out_valid,
  input  logic                          out_ready,
  output qxmm_pkg::div_in_t             out_data
);

  logic                   v1;
  logic                   v2;
  logic                   en1;
  logic                   en2;
  qxmm_pkg::mix_vec_t     mix;
  qxmm_pkg::mix_vec_t     mix_next;
  qxmm_pkg::div_in_t      opnd;
  qxmm_pkg::div_in_t      opnd_next;

  assign en2      = !v2 || out_ready;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  // stage 1: mixes
  always_comb begin
    logic signed [qxmm_pkg::MIX_W-1:0] t;
    logic signed [qxmm_pkg::MIX_W-1:0] r;
    logic signed [qxmm_pkg::MIX_W-1:0] p;
    logic signed [qxmm_pkg::MIX_W-1:0] y;
    t = qxmm_pkg::sx(throttle_cmd);
    r = qxmm_pkg::sx(roll_cmd);
    p = qxmm_pkg::sx(pitch_cmd);
    y = qxmm_pkg::sx(yaw_cmd);
    if (t > qxmm_pkg::ONE_S) begin
      t = qxmm_pkg::ONE_S;
    end
    if (t < 0) begin
      t = '0;
    end
    mix_next[0] = t + r - p + y;
    mix_next[1] = t - r + p + y;
    mix_next[2] = t + r + p - y;
    mix_next[3] = t - r - p - y;
  end

  // stage 2: largest mix picks the divisor; no scaling divides by 1.0
  always_comb begin
    logic signed [qxmm_pkg::MIX_W-1:0] mx;
    mx = qxmm_pkg::smax(qxmm_pkg::smax($signed(mix[0]), $signed(mix[1])),
                        qxmm_pkg::smax($signed(mix[2]), $signed(mix[3])));
    opnd_next.divisor = (mx > qxmm_pkg::ONE_S) ? $unsigned(mx) : qxmm_pkg::ONE;
    for (int l = 0; l < qxmm_pkg::LANES; l++) begin
      opnd_next.num[l] = ($signed(mix[l]) > 0) ? $unsigned(mix[l]) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
    end
    if (en1) mix  <= mix_next;
    if (en2) opnd <= opnd_next;
  end

  assign out_valid = v2;
  assign out_data  = opnd;

  // each dividend stays at or below its divisor, so quotients never pass 1.0
  generate
    for (genvar l = 0; l < qxmm_pkg::LANES; l++) begin : g_chk
      a_num_le_div: assert property (@(posedge clk) disable iff (rst)
        v2 |-> opnd.num[l] <= opnd.divisor)
        else $error("mix above divisor");
    end
  endgenerate

  a_div_ge_one: assert property (@(posedge clk) disable iff (rst)
    v2 |-> opnd.divisor >= qxmm_pkg::ONE)
    else $error("divisor below one");

endmodule

// ===== rtl/qxmm_div.sv =====
// ----------------------------------------------------------------------------
// qxmm_div
// pipelined restoring divider, four lanes sharing one divisor
// ----------------------------------------------------------------------------
module qxmm_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  qxmm_pkg::div_in_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output qxmm_pkg::quot_vec_t           out_quot
);

  localparam int NS = qxmm_pkg::DIV_STAGES;

  logic [NS-1:0]          v;
  logic [NS-1:0]          en;
  logic [NS:1]            rdy;
  logic [NS-1:0]          vin;
  qxmm_pkg::div_stage_t   st   [NS];
  qxmm_pkg::div_stage_t   link [NS];

  assign rdy = {out_ready, en[NS-1:1]};
  assign vin = {v[NS-2:0], in_valid};

  // first partial remainder is the mix itself (dividend is mix << FRAC_BITS)
  assign link[0].divisor = in_data.divisor;
  assign link[0].rem     = in_data.num;
  assign link[0].quot    = '0;

  generate
    for (genvar s = 0; s < NS; s++) begin : g_stage
      qxmm_pkg::div_stage_t res;

      if (s < NS-1) begin : g_link
        assign link[s+1] = st[s];
      end

      assign en[s] = !v[s] || rdy[s+1];

      always_comb begin
        logic [qxmm_pkg::DIV_W-1:0] trial;
        res = link[s];
        for (int j = 0; j < qxmm_pkg::STEPS_PER_STAGE; j++) begin
          for (int l = 0; l < qxmm_pkg::LANES; l++) begin
            if (s * qxmm_pkg::STEPS_PER_STAGE + j < qxmm_pkg::DIV_STEPS) begin
              // the leading step yields the 1.0 bit without a shift
              if (s * qxmm_pkg::STEPS_PER_STAGE + j == 0) begin
                trial = res.rem[l];
              end else begin
                trial = {res.rem[l][qxmm_pkg::DIV_W-2:0], 1'b0};
              end
              if (trial >= res.divisor) begin
                res.rem[l]  = trial - res.divisor;
                res.quot[l] = {res.quot[l][qxmm_pkg::Q_W-2:0], 1'b1};
              end else begin
                res.rem[l]  = trial;
                res.quot[l] = {res.quot[l][qxmm_pkg::Q_W-2:0], 1'b0};
              end
            end
          end
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          v[s] <= 1'b0;
        end else if (en[s]) begin
          v[s] <= vin[s];
        end
        if (en[s]) st[s] <= res;
      end
    end
  endgenerate

  assign in_ready  = en[0];
  assign out_valid = v[NS-1];

  always_comb begin
    for (int l = 0; l < qxmm_pkg::LANES; l++) begin
      out_quot[l] = st[NS-1].quot[l];
    end
  end

  generate
    for (genvar l = 0; l < qxmm_pkg::LANES; l++) begin : g_chk
      a_quot_le_one: assert property (@(posedge clk) disable iff (rst)
        v[NS-1] |-> {3'b000, st[NS-1].quot[l]} <= qxmm_pkg::ONE)
        else $error("quotient above one");
      a_rem_lt_div: assert property (@(posedge clk) disable iff (rst)
        v[NS-1] |-> st[NS-1].rem[l] < st[NS-1].divisor)
        else $error("remainder not below divisor");
    end
  endgenerate

endmodule

// ===== rtl/qxmm_pwm.sv =====
// ----------------------------------------------------------------------------
// qxmm_pwm
// motor command to pulse width: span multiply, then floor offset and clamps
// ----------------------------------------------------------------------------
module qxmm_pwm (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  qxmm_pkg::quot_vec_t           in_quot,
  input  logic [qxmm_pkg::PWM_W-1:0]    pwm_floor,
  input  logic [qxmm_pkg::PWM_W-1:0]    pwm_ceiling,
  output logic                          out_valid,
  input  logic                          out_ready,
  output qxmm_pkg::pwm_vec_t            out_pwm
);

  logic                                          v1;
  logic                                          v2;
  logic                                          en1;
  logic                                          en2;
  logic [qxmm_pkg::LANES-1:0][qxmm_pkg::PROD_W-1:0] prod;
  logic [qxmm_pkg::LANES-1:0][qxmm_pkg::PROD_W-1:0] prod_next;
  qxmm_pkg::pwm_vec_t                            pwm;
  qxmm_pkg::pwm_vec_t                            pwm_next;

  assign en2      = !v2 || out_ready;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  always_comb begin
    for (int l = 0; l < qxmm_pkg::LANES; l++) begin
      prod_next[l] = qxmm_pkg::PROD_W'(in_quot[l]) *
                     qxmm_pkg::PROD_W'(qxmm_pkg::PWM_SPAN);
    end
  end

  // ceiling clamp first, floor clamp last
  always_comb begin
    logic [qxmm_pkg::PWM_W:0] sum;
    sum = '0;
    for (int l = 0; l < qxmm_pkg::LANES; l++) begin
      sum = {1'b0, pwm_floor} +
            (qxmm_pkg::PWM_W+1)'(prod[l][qxmm_pkg::PROD_W-1:qxmm_pkg::FRAC_BITS]);
      if (sum > {1'b0, pwm_ceiling}) begin
        sum = {1'b0, pwm_ceiling};
      end
      if (sum < {1'b0, pwm_floor}) begin
        sum = {1'b0, pwm_floor};
      end
      pwm_next[l] = sum[qxmm_pkg::PWM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
    end
    if (en1) prod <= prod_next;
    if (en2) pwm  <= pwm_next;
  end

  assign out_valid = v2;
  assign out_pwm   = pwm;

endmodule

// ===== rtl/quad_x_motor_mixer_unit.sv =====
// ----------------------------------------------------------------------------
// quad_x_motor_mixer_unit
// quad-x motor mixer: Q2.14 attitude commands to four clamped pulse widths
// ----------------------------------------------------------------------------
//  channel  dir  handshake          content
//  s_*      in   tvalid/tready      throttle, roll, pitch, yaw commands
//  m_*      out  tvalid/tready      four motor pulse widths
//  cfg_*    in   cfg_wr_en          pwm_floor (0), pwm_ceiling (1)
//
//  one item per cycle while m_tready is high; 2 mix, 5 divider, 2 pulse stages
//  15-step quotient mix / max(largest mix, 1.0) spread over 5 divider stages
//  every stage holds its item while the stage after it is full and stalled
//  reset empties the pipeline and loads floor 1000 and ceiling 2000
// ----------------------------------------------------------------------------
module quad_x_motor_mixer_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // throttle_cmd, roll_cmd, pitch_cmd, yaw_cmd
  input  logic [4*qxmm_pkg::CMD_W-1:0]         s_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // front_right_pwm, rear_left_pwm, front_left_pwm, rear_right_pwm
  output logic [4*qxmm_pkg::PWM_W-1:0]         m_tdata,
  input  logic                                 cfg_wr_en,
  input  logic [qxmm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [qxmm_pkg::PWM_W-1:0]           cfg_wdata
);

  logic [qxmm_pkg::PWM_W-1:0] pwm_floor;
  logic [qxmm_pkg::PWM_W-1:0] pwm_ceiling;

  logic                       mix_valid;
  logic                       mix_ready;
  qxmm_pkg::div_in_t          mix_data;
  logic                       div_valid;
  logic                       div_ready;
  qxmm_pkg::quot_vec_t        div_quot;
  qxmm_pkg::pwm_vec_t         pwm_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_floor   <= qxmm_pkg::PWM_FLOOR_RST;
      pwm_ceiling <= qxmm_pkg::PWM_CEILING_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        qxmm_pkg::REG_PWM_FLOOR:   pwm_floor   <= cfg_wdata;
        qxmm_pkg::REG_PWM_CEILING: pwm_ceiling <= cfg_wdata;
      endcase
    end
  end

  qxmm_mix u_mix (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .throttle_cmd (s_tdata[15:0]),
    .roll_cmd     (s_tdata[31:16]),
    .pitch_cmd    (s_tdata[47:32]),
    .yaw_cmd      (s_tdata[63:48]),
    .out_valid    (mix_valid),
    .out_ready    (mix_ready),
    .out_data     (mix_data)
  );

  qxmm_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mix_valid),
    .in_ready  (mix_ready),
    .in_data   (mix_data),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .out_quot  (div_quot)
  );

  qxmm_pwm u_pwm (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (div_valid),
    .in_ready    (div_ready),
    .in_quot     (div_quot),
    .pwm_floor   (pwm_floor),
    .pwm_ceiling (pwm_ceiling),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_pwm     (pwm_out)
  );

  assign m_tdata = pwm_out;

endmodule
